// ===== rtl/core/m3i_pkg.sv =====
// Shared constants and cofactor operand tables for the 3x3 matrix inverse core.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package m3i_pkg;

  // Default element format: signed Q16.16
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Matrix shape
  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned NUM_ROW  = 3;

  // Cofactor k = m[A]*m[B] - m[C]*m[D], elements numbered row*3+col from zero.
  // Cofactor k is already transposed: it feeds inverse element k directly.
  localparam int unsigned COF_A [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_D [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

// ===== rtl/core/m3i_if.sv =====
// Valid/ready channel interfaces: matrix in (m11..m33) and inverse out (r11..r33, flags).
// Depends on m3i_pkg for the default element width.
`default_nettype none

interface m3i_mat_if #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] m11, m12, m13;
  logic signed [ELEM_WIDTH-1:0] m21, m22, m23;
  logic signed [ELEM_WIDTH-1:0] m31, m32, m33;

  modport source (
    output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    input  ready
  );
  modport sink (
    input  valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    output ready
  );
endinterface

interface m3i_inv_if #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] r11, r12, r13;
  logic signed [ELEM_WIDTH-1:0] r21, r22, r23;
  logic signed [ELEM_WIDTH-1:0] r31, r32, r33;
  logic                         singular;
  logic                         overflow;

  modport source (
    output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, singular, overflow,
    input  ready
  );
  modport sink (
    input  valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, singular, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/matrix3x3_inverse_core.sv =====
// Top level of the 3x3 matrix inverse core: cofactor, determinant and divide pipelines.
// Depends on m3i_pkg, m3i_if, m3i_cof, m3i_det and m3i_div.
`default_nettype none

// Inverts one 3x3 matrix of signed fixed-point elements (Q16.16 by default) per cycle by
// the adjugate method. Cofactors and the determinant are exact; each inverse element is
// the cofactor scaled by 2^(2*FRAC_BITS) over the determinant, truncated toward zero and
// saturated, with overflow set if any element saturated. A zero determinant returns all
// zeros with singular set. The pipeline has two cofactor stages, three determinant stages
// and ELEM_WIDTH+4 divide stages, where the restoring divider resolves one quotient bit per
// stage in nine lanes that share the denominator. A new matrix is taken every cycle unless
// back-pressure holds the input. Back-pressure moves back one stage at a time, so empty
// stages keep filling while a result waits, and mat_i.ready is high whenever the output
// stage is empty.
module matrix3x3_inverse_core #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
  parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  m3i_mat_if.sink       mat_i,
  m3i_inv_if.source     inv_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned NE = m3i_pkg::NUM_ELEM;
  localparam int unsigned NR = m3i_pkg::NUM_ROW;

  logic [NE-1:0][W-1:0]   mat;
  logic [NE-1:0][2*W-1:0] cof_a, cof_b;
  logic [NR-1:0][W-1:0]   row;
  logic [3*W:0]           det;
  logic [NE-1:0][W-1:0]   res;
  logic cof_valid, cof_ready, det_valid, det_ready;

  // Gather the matrix, row then column
  assign mat[0] = mat_i.m11;
  assign mat[1] = mat_i.m12;
  assign mat[2] = mat_i.m13;
  assign mat[3] = mat_i.m21;
  assign mat[4] = mat_i.m22;
  assign mat[5] = mat_i.m23;
  assign mat[6] = mat_i.m31;
  assign mat[7] = mat_i.m32;
  assign mat[8] = mat_i.m33;

  m3i_cof #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mat_i.valid),
    .ready_o (mat_i.ready),
    .m_i     (mat),
    .valid_o (cof_valid),
    .ready_i (cof_ready),
    .cof_o   (cof_a),
    .row_o   (row)
  );

  m3i_det #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .ready_o (cof_ready),
    .cof_i   (cof_a),
    .row_i   (row),
    .valid_o (det_valid),
    .ready_i (det_ready),
    .cof_o   (cof_b),
    .det_o   (det)
  );

  m3i_div #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (det_valid),
    .ready_o    (det_ready),
    .cof_i      (cof_b),
    .det_i      (det),
    .valid_o    (inv_o.valid),
    .ready_i    (inv_o.ready),
    .res_o      (res),
    .singular_o (inv_o.singular),
    .overflow_o (inv_o.overflow)
  );

  // Scatter the inverse, row then column
  assign inv_o.r11 = res[0];
  assign inv_o.r12 = res[1];
  assign inv_o.r13 = res[2];
  assign inv_o.r21 = res[3];
  assign inv_o.r22 = res[4];
  assign inv_o.r23 = res[5];
  assign inv_o.r31 = res[6];
  assign inv_o.r32 = res[7];
  assign inv_o.r33 = res[8];

endmodule

`default_nettype wire

// ===== rtl/core/m3i_cof.sv =====
// Cofactor stages: eighteen element products, then nine exact cofactor differences.
// Depends on m3i_pkg for the cofactor operand tables.
`default_nettype none

module m3i_cof #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [m3i_pkg::NUM_ELEM-1:0][ELEM_WIDTH-1:0]   m_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [m3i_pkg::NUM_ELEM-1:0][2*ELEM_WIDTH-1:0] cof_o,
  output logic [m3i_pkg::NUM_ROW-1:0][ELEM_WIDTH-1:0]    row_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned PW = 2 * W;

  logic prod_v_q, cof_v_q;
  logic prod_en, cof_en;

  logic signed [PW-1:0] pa_d   [m3i_pkg::NUM_ELEM];
  logic signed [PW-1:0] pb_d   [m3i_pkg::NUM_ELEM];
  logic signed [PW-1:0] pa_q   [m3i_pkg::NUM_ELEM];
  logic signed [PW-1:0] pb_q   [m3i_pkg::NUM_ELEM];
  logic signed [PW-1:0] cof_d  [m3i_pkg::NUM_ELEM];
  logic signed [PW-1:0] cof_q  [m3i_pkg::NUM_ELEM];
  logic [m3i_pkg::NUM_ROW-1:0][W-1:0] row_a_q, row_b_q;

  // Advance a stage when it is empty or the next one advances
  assign cof_en  = !cof_v_q || ready_i;
  assign prod_en = !prod_v_q || cof_en;
  assign ready_o = prod_en;
  assign valid_o = cof_v_q;
  assign row_o   = row_b_q;

  // Products, then differences; a cofactor always fits in 2W signed bits
  for (genvar k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_lane
    assign pa_d[k]  = $signed(m_i[m3i_pkg::COF_A[k]]) * $signed(m_i[m3i_pkg::COF_B[k]]);
    assign pb_d[k]  = $signed(m_i[m3i_pkg::COF_C[k]]) * $signed(m_i[m3i_pkg::COF_D[k]]);
    assign cof_d[k] = pa_q[k] - pb_q[k];
    assign cof_o[k] = cof_q[k];
  end

  // Track valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      cof_v_q  <= 1'b0;
    end else begin
      if (prod_en) prod_v_q <= valid_i;
      if (cof_en)  cof_v_q  <= prod_v_q;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      row_a_q <= m_i[m3i_pkg::NUM_ROW-1:0];
    end
    if (cof_en) begin
      cof_q   <= cof_d;
      row_b_q <= row_a_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/m3i_det.sv =====
// Determinant stages: split partial products, row terms, three-way sum.
// Depends on m3i_pkg for matrix shape constants.
`default_nettype none

module m3i_det #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [m3i_pkg::NUM_ELEM-1:0][2*ELEM_WIDTH-1:0] cof_i,
  input  logic [m3i_pkg::NUM_ROW-1:0][ELEM_WIDTH-1:0]    row_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [m3i_pkg::NUM_ELEM-1:0][2*ELEM_WIDTH-1:0] cof_o,
  output logic [3*ELEM_WIDTH:0]                          det_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned DW = 3 * W + 1;

  logic pp_v_q, term_v_q, det_v_q;
  logic pp_en, term_en, det_en;

  logic signed [PW:0]   plo_d  [m3i_pkg::NUM_ROW];
  logic signed [PW:0]   plo_q  [m3i_pkg::NUM_ROW];
  logic signed [PW-1:0] phi_d  [m3i_pkg::NUM_ROW];
  logic signed [PW-1:0] phi_q  [m3i_pkg::NUM_ROW];
  logic signed [DW-1:0] term_d [m3i_pkg::NUM_ROW];
  logic signed [DW-1:0] term_q [m3i_pkg::NUM_ROW];
  logic signed [DW-1:0] det_d, det_q;
  logic [m3i_pkg::NUM_ELEM-1:0][PW-1:0] cof_c_q, cof_d_q, cof_e_q;

  assign det_en  = !det_v_q || ready_i;
  assign term_en = !term_v_q || det_en;
  assign pp_en   = !pp_v_q || term_en;
  assign ready_o = pp_en;
  assign valid_o = det_v_q;
  assign cof_o   = cof_e_q;
  assign det_o   = det_q;

  // Expand along the first row: m1k times cofactor of column k (cofactor index 3k)
  for (genvar k = 0; k < m3i_pkg::NUM_ROW; k++) begin : g_row
    // Split the cofactor into an unsigned low half and a signed high half
    assign plo_d[k]  = $signed(row_i[k]) * $signed({1'b0, cof_i[3*k][W-1:0]});
    assign phi_d[k]  = $signed(row_i[k]) * $signed(cof_i[3*k][PW-1:W]);
    // Recombine the halves at full width
    assign term_d[k] = (DW'(phi_q[k]) <<< W) + DW'(plo_q[k]);
  end

  assign det_d = term_q[0] + term_q[1] + term_q[2];

  // Track valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q   <= 1'b0;
      term_v_q <= 1'b0;
      det_v_q  <= 1'b0;
    end else begin
      if (pp_en)   pp_v_q   <= valid_i;
      if (term_en) term_v_q <= pp_v_q;
      if (det_en)  det_v_q  <= term_v_q;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (pp_en) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      cof_c_q <= cof_i;
    end
    if (term_en) begin
      term_q  <= term_d;
      cof_d_q <= cof_c_q;
    end
    if (det_en) begin
      det_q   <= det_d;
      cof_e_q <= cof_d_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/m3i_div.sv =====
// Divide stages: magnitudes, range check, one restoring quotient bit per stage in nine
// lanes sharing one denominator, then sign, saturation and the singular case.
// Depends on m3i_pkg for matrix shape constants.
`default_nettype none

module m3i_div #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
  parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [m3i_pkg::NUM_ELEM-1:0][2*ELEM_WIDTH-1:0] cof_i,
  input  logic [3*ELEM_WIDTH:0]                          det_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [m3i_pkg::NUM_ELEM-1:0][ELEM_WIDTH-1:0]   res_o,
  output logic                                           singular_o,
  output logic                                           overflow_o
);

  localparam int unsigned W     = ELEM_WIDTH;
  localparam int unsigned NE    = m3i_pkg::NUM_ELEM;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned DW    = 3 * W + 1;
  localparam int unsigned RW    = 3 * W;
  localparam int unsigned QW    = W + 1;
  localparam int unsigned NUMW  = 2 * W + 2 * FRAC_BITS;
  localparam int unsigned XW    = (NUMW > RW) ? NUMW : RW;
  localparam int unsigned NSTEP = QW;
  // prep, range check, NSTEP quotient steps, output
  localparam int unsigned NS    = NSTEP + 3;

  localparam logic [QW-1:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  // Prep stage
  logic [PW-1:0] acof_d [NE];
  logic [PW-1:0] acof_q [NE];
  logic [NE-1:0] neg_p_d, neg_p_q;
  logic [DW-1:0] det_abs;
  logic [RW-1:0] aden_p_q;
  logic          sing_p_q;

  // Range check stage (index 0) and quotient steps (1..NSTEP)
  logic [RW-1:0] rem_q  [NSTEP+1][NE];
  logic [QW-1:0] qn_q   [NSTEP+1][NE];
  logic [NE-1:0] high_q [NSTEP+1];
  logic [NE-1:0] neg_q  [NSTEP+1];
  logic [RW-1:0] den_q  [NSTEP+1];
  logic [NSTEP:0] sing_q;

  // Output stage
  logic [NE-1:0][W-1:0] res_d, res_q;
  logic [NE-1:0]        sat;
  logic                 ovf_d, ovf_q, sing_out_q;

  // Stall ripples back one stage at a time, so bubbles close up
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o    = en[0];
  assign valid_o    = v_q[NS-1];
  assign res_o      = res_q;
  assign singular_o = sing_out_q;
  assign overflow_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Take magnitudes and quotient signs
  assign det_abs = det_i[DW-1] ? (~det_i + DW'(1)) : det_i;

  for (genvar k = 0; k < NE; k++) begin : g_prep
    assign acof_d[k]  = cof_i[k][PW-1] ? (~cof_i[k] + PW'(1)) : cof_i[k];
    assign neg_p_d[k] = cof_i[k][PW-1] ^ det_i[DW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      acof_q   <= acof_d;
      neg_p_q  <= neg_p_d;
      aden_p_q <= det_abs[RW-1:0];
      sing_p_q <= (det_i == '0);
    end
  end

  // Range check: quotient reaches 2^(W+1) exactly when the numerator bits above the
  // low W+1 already cover the denominator
  for (genvar k = 0; k < NE; k++) begin : g_chk
    logic [NUMW-1:0] num;
    logic [NUMW-1:0] rem0;
    assign num  = NUMW'(acof_q[k]) << (2 * FRAC_BITS);
    assign rem0 = num >> QW;

    always_ff @(posedge clk_i) begin
      if (en[1]) begin
        rem_q[0][k]  <= RW'(rem0);
        qn_q[0][k]   <= num[QW-1:0];
        high_q[0][k] <= XW'(rem0) >= XW'(aden_p_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      neg_q[0]  <= neg_p_q;
      den_q[0]  <= aden_p_q;
      sing_q[0] <= sing_p_q;
    end
  end

  // Restoring division: shift in the next numerator bit, subtract if it fits.
  // qn holds the unused numerator bits on top and collects quotient bits below.
  for (genvar s = 1; s <= NSTEP; s++) begin : g_step
    for (genvar k = 0; k < NE; k++) begin : g_lane
      logic [RW:0]   r2;
      logic [RW+1:0] diff;
      logic          ge;
      assign r2   = {rem_q[s-1][k], qn_q[s-1][k][QW-1]};
      assign diff = {1'b0, r2} - {2'b00, den_q[s-1]};
      assign ge   = !diff[RW+1];

      always_ff @(posedge clk_i) begin
        if (en[s+1]) begin
          rem_q[s][k] <= ge ? diff[RW-1:0] : r2[RW-1:0];
          qn_q[s][k]  <= {qn_q[s-1][k][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s+1]) begin
        high_q[s] <= high_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        den_q[s]  <= den_q[s-1];
        sing_q[s] <= sing_q[s-1];
      end
    end
  end

  // Saturate, apply sign, zero everything for a singular matrix
  for (genvar k = 0; k < NE; k++) begin : g_out
    logic [QW-1:0] lim;
    logic [QW-1:0] qv;
    logic [QW-1:0] sv;
    assign lim      = neg_q[NSTEP][k] ? LIM_NEG : LIM_POS;
    assign sat[k]   = high_q[NSTEP][k] || (qn_q[NSTEP][k] > lim);
    assign qv       = sat[k] ? lim : qn_q[NSTEP][k];
    assign sv       = neg_q[NSTEP][k] ? (QW'(0) - qv) : qv;
    assign res_d[k] = sing_q[NSTEP] ? '0 : sv[W-1:0];
  end

  assign ovf_d = !sing_q[NSTEP] && (|sat);

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      res_q      <= res_d;
      ovf_q      <= ovf_d;
      sing_out_q <= sing_q[NSTEP];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/m3i_chk.sv =====
// Port-level checker for matrix3x3_inverse_core, attached by the bind at the end.
// Depends on m3i_pkg; sees only the top level's ports.
`default_nettype none

module m3i_chk #(
  parameter int unsigned ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
) (
  input logic clk_i,
  input logic rst_ni,
  input logic mat_valid_i,
  input logic mat_ready_i,
  input logic inv_valid_i,
  input logic inv_ready_i,
  input logic [m3i_pkg::NUM_ELEM*ELEM_WIDTH+1:0] inv_data_i
);

  // One matrix per pipeline stage at most
  localparam int unsigned DEPTH = ELEM_WIDTH + 9;
  localparam int unsigned CW    = $clog2(DEPTH + 2);

  logic          in_xfer, out_xfer;
  logic [CW-1:0] live_q;

  assign in_xfer  = mat_valid_i && mat_ready_i;
  assign out_xfer = inv_valid_i && inv_ready_i;

  // Count matrices taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_q + CW'(in_xfer) - CW'(out_xfer);
    end
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_valid_i && !inv_ready_i |=> inv_valid_i && $stable(inv_data_i))
    else $error("result changed or dropped while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> live_q != '0)
    else $error("result transfer with no matrix in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(DEPTH))
    else $error("more matrices in flight than pipeline stages");

  a_decoupled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inv_valid_i |-> mat_ready_i)
    else $error("input stalled with an empty output stage");

endmodule

bind matrix3x3_inverse_core m3i_chk #(
  .ELEM_WIDTH(ELEM_WIDTH)
) u_m3i_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .mat_valid_i (mat_i.valid),
  .mat_ready_i (mat_i.ready),
  .inv_valid_i (inv_o.valid),
  .inv_ready_i (inv_o.ready),
  .inv_data_i  ({inv_o.r11, inv_o.r12, inv_o.r13, inv_o.r21, inv_o.r22, inv_o.r23,
                 inv_o.r31, inv_o.r32, inv_o.r33, inv_o.singular, inv_o.overflow})
);

`default_nettype wire

// ===== test/tb_matrix3x3_inverse_core.sv =====
// Self-checking testbench for matrix3x3_inverse_core: drives matrices over m3i_mat_if and
// checks every inverse on m3i_inv_if against an exact wide-integer adjugate predictor.
// Depends on m3i_pkg, m3i_if and the core RTL.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_core;

  localparam int EW = m3i_pkg::ELEM_WIDTH;
  localparam int FB = m3i_pkg::FRAC_BITS;
  // Wide enough for |cofactor| << 2*FB and |det| with margin
  localparam int WW = 4 * EW + 2 * FB + 8;
  localparam int LATENCY = EW + 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 450;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [EW-1:0] elem_t;
  // Element k is row*3+col, zero based, e[0] = m11
  typedef struct packed {
    logic [0:8][EW-1:0] e;
  } matrix_t;
  typedef struct packed {
    logic [0:8][EW-1:0] e;
    logic               singular;
    logic               overflow;
  } inverse_t;

  typedef enum int {
    SH_WIDE, SH_MODERATE, SH_TINY, SH_EXTREME, SH_DIAGONAL, SH_RANK2, SH_RANK1, SH_ZERO_LINE
  } shape_e;

  localparam elem_t Z    = '0;
  localparam elem_t ONE  = elem_t'(1) <<< FB;
  localparam elem_t MAXV = {1'b0, {(EW - 1){1'b1}}};
  localparam elem_t MINV = {1'b1, {(EW - 1){1'b0}}};
  localparam wide_t HALF = wide_t'(1) <<< (EW - 1);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  m3i_mat_if mat_if ();
  m3i_inv_if inv_if ();

  matrix3x3_inverse_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_if),
    .inv_o  (inv_if)
  );

  matrix_t  matrix_q[$];
  inverse_t inverse_q[$];
  matrix_t  on_bus;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       mismatches = 0;
  int       cycle_count = 0;

  always #2 clk_i = ~clk_i;

  // Exact adjugate inverse: truncate toward zero, saturate to EW bits
  function automatic inverse_t invert(matrix_t a);
    wide_t    x[9];
    wide_t    cof[9];
    wide_t    det, num, den, quo, lim;
    logic     neg;
    inverse_t res;
    res = '0;
    for (int k = 0; k < 9; k++) x[k] = $signed(a.e[k]);
    // Cofactors already transposed: cof[k] feeds inverse element k
    cof[0] = x[4] * x[8] - x[5] * x[7];
    cof[1] = x[2] * x[7] - x[1] * x[8];
    cof[2] = x[1] * x[5] - x[2] * x[4];
    cof[3] = x[5] * x[6] - x[3] * x[8];
    cof[4] = x[0] * x[8] - x[2] * x[6];
    cof[5] = x[2] * x[3] - x[0] * x[5];
    cof[6] = x[3] * x[7] - x[4] * x[6];
    cof[7] = x[1] * x[6] - x[0] * x[7];
    cof[8] = x[0] * x[4] - x[1] * x[3];
    det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      den = (det < 0) ? -det : det;
      for (int k = 0; k < 9; k++) begin
        neg = cof[k][WW-1] ^ det[WW-1];
        num = (cof[k] < 0) ? -cof[k] : cof[k];
        num = num <<< (2 * FB);
        quo = num / den;
        lim = neg ? HALF : HALF - 1;
        if (quo > lim) begin
          quo = lim;
          res.overflow = 1'b1;
        end
        if (neg) quo = -quo;
        res.e[k] = quo[EW-1:0];
      end
    end
    return res;
  endfunction

  // Random value with magnitude below 2^bits, either sign
  function automatic elem_t rand_signed(int unsigned bits);
    logic [63:0] w;
    w = {$urandom(), $urandom()} & ((64'd1 << bits) - 64'd1);
    if ($urandom_range(1) == 1) w = -w;
    return w[EW-1:0];
  endfunction

  function automatic elem_t fx(int k);
    return elem_t'(k) <<< FB;
  endfunction

  function automatic matrix_t diag3(elem_t a, elem_t b, elem_t c);
    matrix_t mx;
    mx.e = {a, Z, Z, Z, b, Z, Z, Z, c};
    return mx;
  endfunction

  function automatic matrix_t random_matrix(shape_e sh);
    matrix_t     mx;
    logic [63:0] w;
    wide_t       t;
    elem_t       v[3];
    elem_t       tmp;
    int          ka, kb, line;
    mx = '0;
    case (sh)
      SH_WIDE: begin
        for (int k = 0; k < 9; k++) begin
          w = {$urandom(), $urandom()};
          mx.e[k] = w[EW-1:0];
        end
      end
      SH_MODERATE: begin
        for (int k = 0; k < 9; k++) mx.e[k] = rand_signed(FB + 3);
      end
      SH_TINY: begin
        for (int k = 0; k < 9; k++) mx.e[k] = rand_signed($urandom_range(1, 10));
      end
      SH_EXTREME: begin
        for (int k = 0; k < 9; k++) begin
          case ($urandom_range(7))
            0: mx.e[k] = Z;
            1: mx.e[k] = elem_t'(1);
            2: mx.e[k] = '1;
            3: mx.e[k] = MAXV;
            4: mx.e[k] = MINV;
            5: mx.e[k] = ONE;
            6: mx.e[k] = -ONE;
            default: mx.e[k] = rand_signed(EW - 1);
          endcase
        end
      end
      SH_DIAGONAL: begin
        for (int k = 0; k < 9; k++) begin
          if (k % 4 == 0) mx.e[k] = rand_signed($urandom_range(1, EW - 1));
          else if ($urandom_range(1) == 1) mx.e[k] = rand_signed($urandom_range(0, 12));
        end
      end
      SH_RANK2: begin
        // Third row is an integer combination of the first two
        ka = $urandom_range(6) - 3;
        kb = $urandom_range(6) - 3;
        for (int c = 0; c < 3; c++) begin
          mx.e[c] = rand_signed(FB + 2);
          mx.e[3 + c] = rand_signed(FB + 2);
          t = ka * $signed(mx.e[c]) + kb * $signed(mx.e[3 + c]);
          mx.e[6 + c] = t[EW-1:0];
        end
        // Move the dependency to the columns half the time
        if ($urandom_range(1) == 1) begin
          for (int r = 0; r < 3; r++)
            for (int c = r + 1; c < 3; c++) begin
              tmp = mx.e[r * 3 + c];
              mx.e[r * 3 + c] = mx.e[c * 3 + r];
              mx.e[c * 3 + r] = tmp;
            end
        end
      end
      SH_RANK1: begin
        for (int c = 0; c < 3; c++) v[c] = rand_signed(12);
        for (int r = 0; r < 3; r++) begin
          ka = $urandom_range(16) - 8;
          for (int c = 0; c < 3; c++) begin
            t = ka * $signed(v[c]);
            mx.e[r * 3 + c] = t[EW-1:0];
          end
        end
      end
      default: begin
        for (int k = 0; k < 9; k++) mx.e[k] = rand_signed(FB + 3);
        line = $urandom_range(2);
        if ($urandom_range(1) == 1) begin
          for (int c = 0; c < 3; c++) mx.e[line * 3 + c] = Z;
        end else begin
          for (int r = 0; r < 3; r++) mx.e[r * 3 + line] = Z;
        end
      end
    endcase
    return mx;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] %s", $time, what);
  endtask

  // Driver: record the accepted matrix, then present the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mat_if.valid <= 1'b0;
    end else begin
      if (mat_if.valid && mat_if.ready) inverse_q.push_back(invert(on_bus));
      if (!mat_if.valid || mat_if.ready) begin
        if (matrix_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = matrix_q.pop_front();
          mat_if.valid <= 1'b1;
          mat_if.m11 <= on_bus.e[0];
          mat_if.m12 <= on_bus.e[1];
          mat_if.m13 <= on_bus.e[2];
          mat_if.m21 <= on_bus.e[3];
          mat_if.m22 <= on_bus.e[4];
          mat_if.m23 <= on_bus.e[5];
          mat_if.m31 <= on_bus.e[6];
          mat_if.m32 <= on_bus.e[7];
          mat_if.m33 <= on_bus.e[8];
        end else begin
          mat_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected inverse
  always @(posedge clk_i) begin
    inverse_t got, want;
    if (!rst_ni) begin
      inv_if.ready <= 1'b0;
    end else begin
      if (inv_if.valid && inv_if.ready) begin
        got.e = {inv_if.r11, inv_if.r12, inv_if.r13, inv_if.r21, inv_if.r22, inv_if.r23,
                 inv_if.r31, inv_if.r32, inv_if.r33};
        got.singular = inv_if.singular;
        got.overflow = inv_if.overflow;
        if (inverse_q.size() == 0) begin
          report_mismatch("result transfer with no matrix outstanding");
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got.e[k] !== want.e[k])
              report_mismatch($sformatf("r%0d%0d: got %0d, expected %0d", k / 3 + 1,
                                        k % 3 + 1, $signed(got.e[k]), $signed(want.e[k])));
          if (got.singular !== want.singular)
            report_mismatch($sformatf("singular: got %b, expected %b",
                                      got.singular, want.singular));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow: got %b, expected %b",
                                      got.overflow, want.overflow));
        end
      end
      inv_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("matrix3x3_inverse_core: mismatch");
      $finish;
    end
  end

  // Stimulus: directed corners, then random shapes under three idle patterns
  initial begin
    matrix_t mx;
    int      pick;
    mat_if.valid = 1'b0;
    mat_if.m11 = '0;
    mat_if.m12 = '0;
    mat_if.m13 = '0;
    mat_if.m21 = '0;
    mat_if.m22 = '0;
    mat_if.m23 = '0;
    mat_if.m31 = '0;
    mat_if.m32 = '0;
    mat_if.m33 = '0;
    inv_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin tx_idle_pct = 11; rx_idle_pct = 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct = 11; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        matrix_q.push_back(diag3(ONE, ONE, ONE));
        matrix_q.push_back(diag3(Z, Z, Z));
        matrix_q.push_back(diag3(-ONE, -ONE, -ONE));
        mx.e = {9{MAXV}};
        matrix_q.push_back(mx);
        mx.e = {9{MINV}};
        matrix_q.push_back(mx);
        // One-LSB diagonal: inverse far above range, both signs
        matrix_q.push_back(diag3(elem_t'(1), elem_t'(1), elem_t'(1)));
        matrix_q.push_back(diag3('1, '1, '1));
        // Two-LSB diagonal: just past the positive limit, exactly the negative limit
        matrix_q.push_back(diag3(elem_t'(2), elem_t'(2), elem_t'(2)));
        matrix_q.push_back(diag3(-elem_t'(2), -elem_t'(2), -elem_t'(2)));
        matrix_q.push_back(diag3(MAXV, MAXV, MAXV));
        matrix_q.push_back(diag3(MINV, MINV, MINV));
        matrix_q.push_back(diag3(MINV, MAXV, ONE));
        matrix_q.push_back(diag3(MAXV, MINV, elem_t'(1)));
        // Odd permutation, negative determinant
        mx.e = {Z, ONE, Z, ONE, Z, Z, Z, Z, ONE};
        matrix_q.push_back(mx);
        mx.e = {ONE, fx(2), fx(3), Z, ONE, fx(4), Z, Z, ONE};
        matrix_q.push_back(mx);
        mx.e = {fx(2), -ONE, Z, -ONE, fx(2), -ONE, Z, -ONE, fx(2)};
        matrix_q.push_back(mx);
        // Inexact quotients truncate toward zero
        matrix_q.push_back(diag3(fx(3), fx(3), fx(3)));
        matrix_q.push_back(diag3(-fx(3), fx(7), -fx(11)));
        // Dependent rows and an empty column
        mx.e = {ONE, fx(2), fx(3), ONE, fx(2), fx(3), fx(4), fx(5), fx(6)};
        matrix_q.push_back(mx);
        mx.e = {ONE, Z, fx(3), fx(4), Z, fx(6), fx(7), Z, fx(9)};
        matrix_q.push_back(mx);
        mx.e = {MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV};
        matrix_q.push_back(mx);
        matrix_q.push_back(diag3({(EW / 2){2'b01}}, {(EW / 2){2'b10}}, {(EW / 2){2'b01}}));
        mx.e = {Z, Z, MINV, Z, MAXV, Z, MINV, Z, Z};
        matrix_q.push_back(mx);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) matrix_q.push_back(random_matrix(SH_MODERATE));
        else if (pick < 47) matrix_q.push_back(random_matrix(SH_DIAGONAL));
        else if (pick < 57) matrix_q.push_back(random_matrix(SH_RANK2));
        else if (pick < 62) matrix_q.push_back(random_matrix(SH_RANK1));
        else if (pick < 67) matrix_q.push_back(random_matrix(SH_ZERO_LINE));
        else if (pick < 77) matrix_q.push_back(random_matrix(SH_TINY));
        else if (pick < 88) matrix_q.push_back(random_matrix(SH_WIDE));
        else matrix_q.push_back(random_matrix(SH_EXTREME));
      end

      // Hold the sender until every expected inverse has come back
      while (matrix_q.size() != 0 || mat_if.valid || inverse_q.size() != 0)
        @(negedge clk_i);
    end

    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("matrix3x3_inverse_core: match");
    end else begin
      $display("matrix3x3_inverse_core: mismatch");
    end
    $finish;
  end

endmodule
